// ----- rtl/htbd_pkg.sv -----
// htbd_pkg: shared types, constants and helpers of the huffman tree decoder
// no dependencies; used by every rtl file of the block but htbd_ram
package htbd_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int NODE_AW = $clog2(NODE_COUNT);

  localparam logic [8:0] INTERNAL_SYM = 9'd257;
  localparam logic [8:0] MAX_BYTE_SYM = 9'd255;

  localparam logic CFG_ROOT_NODE = 1'b0;
  localparam logic CFG_MAX_OUTPUT = 1'b1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_SYMBOL = 3'd0,
    KIND_DONE = 3'd1,
    KIND_BAD = 3'd2,
    KIND_FULL = 3'd3,
    KIND_NOTREE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DECODE = 2'd1,
    PH_HALT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_CUR,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic written;
    logic [8:0] sym;
    logic [9:0] left;
    logic [9:0] right;
  } node_t;

  typedef struct packed {
    op_t op;
    logic node_ok;
    logic [9:0] idx;
    node_t entry;
    logic [7:0] data;
    logic last;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] symbol;
    logic [15:0] count;
    logic last;
  } res_t;

  function automatic logic node_in_range(logic [9:0] idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

  function automatic logic [NODE_AW-1:0] node_addr(logic [9:0] idx);
    return NODE_AW'(idx);
  endfunction

endpackage

// ----- rtl/htbd_ram.sv -----
// htbd_ram: generic single write port, single read port ram, registered read
// no dependencies
module htbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/htbd_front.sv -----
// htbd_front: accepts input beats, classifies them and queues commands
// depends on htbd_pkg
module htbd_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic opcode,
  input  logic [9:0] node_index,
  input  logic [8:0] node_symbol,
  input  logic [9:0] left_child,
  input  logic [9:0] right_child,
  input  logic [7:0] data_byte,
  input  logic last_byte,
  input  logic clearing,
  output logic cmd_valid,
  output htbd_pkg::cmd_t cmd,
  input  logic cmd_pop
);

  htbd_pkg::cmd_t q [2];
  htbd_pkg::cmd_t in_cmd;
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic do_push;
  logic do_pop;

  always_comb begin
    in_cmd.op = htbd_pkg::op_t'(opcode);
    in_cmd.node_ok = htbd_pkg::node_in_range(node_index);
    in_cmd.idx = node_index;
    in_cmd.entry.written = 1'b1;
    in_cmd.entry.sym = node_symbol;
    in_cmd.entry.left = left_child;
    in_cmd.entry.right = right_child;
    in_cmd.data = data_byte;
    in_cmd.last = last_byte;
  end

  assign full = (fill == 2'd2) || clearing;
  assign do_push = push && !full;
  assign cmd_valid = (fill != 2'd0);
  assign do_pop = cmd_pop && cmd_valid;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- rtl/htbd_res_queue.sv -----
// htbd_res_queue: two-entry result queue toward the output side
// depends on htbd_pkg
module htbd_res_queue (
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  htbd_pkg::res_t res_in,
  output logic res_space,
  output logic empty,
  input  logic pop,
  output htbd_pkg::res_t res_out
);

  htbd_pkg::res_t q [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic do_push;
  logic do_pop;

  assign res_space = (fill != 2'd2);
  assign empty = (fill == 2'd0);
  assign do_push = res_push && res_space;
  assign do_pop = pop && !empty;
  assign res_out = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- rtl/htbd_back.sv -----
// htbd_back: node table, configuration registers and the tree walk engine
// depends on htbd_pkg and htbd_ram
module htbd_back (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [15:0] cfg_data,
  input  logic cmd_valid,
  input  htbd_pkg::cmd_t cmd,
  output logic cmd_pop,
  output logic clearing,
  output logic res_push,
  output htbd_pkg::res_t res,
  input  logic res_space
);

  htbd_pkg::state_t state;
  htbd_pkg::state_t state_next;
  htbd_pkg::phase_t phase;
  htbd_pkg::phase_t phase_next;
  htbd_pkg::kind_t halt_kind;
  htbd_pkg::kind_t halt_kind_next;
  logic [9:0] cur_idx;
  logic [9:0] cur_idx_next;
  logic [9:0] child_idx;
  logic [9:0] child_idx_next;
  logic child_ok;
  logic child_ok_next;
  htbd_pkg::node_t root_entry;
  htbd_pkg::node_t root_entry_next;
  logic root_ok;
  logic root_ok_next;
  logic [2:0] bit_cnt;
  logic [2:0] bit_cnt_next;
  logic [7:0] byte_reg;
  logic [7:0] byte_reg_next;
  logic last_reg;
  logic last_reg_next;
  logic [15:0] symbols;
  logic [15:0] symbols_next;
  logic [9:0] root_node;
  logic [15:0] max_output;
  logic [htbd_pkg::NODE_AW-1:0] clr_addr;

  logic ram_we;
  logic [htbd_pkg::NODE_AW-1:0] ram_waddr;
  htbd_pkg::node_t ram_wdata;
  logic ram_re;
  logic [htbd_pkg::NODE_AW-1:0] ram_raddr;
  htbd_pkg::node_t rd_data;

  // step on a node: halt or fetch the child for the chosen bit
  htbd_pkg::node_t step_node;
  logic step_ok;
  logic step_bit;
  logic step_halt;
  htbd_pkg::kind_t step_kind;
  logic [9:0] step_child;

  // evaluation of a fetched child in the walk
  logic walk_halt;
  htbd_pkg::kind_t walk_kind;
  logic walk_emit;
  logic walk_more;
  logic walk_stall;
  logic root_start_ok;

  htbd_ram #(
    .WIDTH($bits(htbd_pkg::node_t)),
    .DEPTH(htbd_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign cfg_ready = 1'b1;
  assign clearing = (state == htbd_pkg::ST_CLEAR);

  always_comb begin
    step_halt = 1'b0;
    step_kind = htbd_pkg::KIND_DONE;
    step_child = step_bit ? step_node.right : step_node.left;
    if (!(step_ok && step_node.written)) begin
      step_halt = 1'b1;
      step_kind = htbd_pkg::KIND_DONE;
    end else if (step_node.sym != htbd_pkg::INTERNAL_SYM) begin
      step_halt = 1'b1;
      step_kind = (step_node.sym > htbd_pkg::MAX_BYTE_SYM) ? htbd_pkg::KIND_BAD
                                                             : htbd_pkg::KIND_FULL;
    end
  end

  always_comb begin
    walk_halt = 1'b0;
    walk_kind = htbd_pkg::KIND_DONE;
    walk_emit = 1'b0;
    if (!(child_ok && rd_data.written)) begin
      walk_halt = 1'b1;
      walk_kind = htbd_pkg::KIND_DONE;
    end else if (rd_data.sym == htbd_pkg::INTERNAL_SYM) begin
      walk_halt = 1'b0;
    end else if (rd_data.sym > htbd_pkg::MAX_BYTE_SYM) begin
      walk_halt = 1'b1;
      walk_kind = htbd_pkg::KIND_BAD;
    end else if (symbols == max_output) begin
      walk_halt = 1'b1;
      walk_kind = htbd_pkg::KIND_FULL;
    end else begin
      walk_emit = 1'b1;
    end
    walk_more = !walk_halt && (bit_cnt != 3'd7);
    walk_stall = walk_emit && !res_space;
  end

  assign root_start_ok = htbd_pkg::node_in_range(root_node) && rd_data.written;

  always_comb begin
    step_node = rd_data;
    step_ok = htbd_pkg::node_in_range(cur_idx);
    step_bit = byte_reg[0];
    if (state == htbd_pkg::ST_WALK) begin
      if (walk_emit) begin
        step_node = root_entry;
        step_ok = root_ok;
      end else begin
        step_node = rd_data;
        step_ok = child_ok;
      end
      step_bit = byte_reg[bit_cnt + 3'd1];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      htbd_pkg::ST_CLEAR: begin
        if (clr_addr == htbd_pkg::NODE_AW'(htbd_pkg::NODE_COUNT - 1)) begin
          state_next = htbd_pkg::ST_IDLE;
        end
      end
      htbd_pkg::ST_IDLE: begin
        if (cmd_valid && cmd.op == htbd_pkg::OP_DECODE) begin
          state_next = htbd_pkg::ST_ROOT;
        end
      end
      htbd_pkg::ST_ROOT: begin
        state_next = htbd_pkg::ST_CUR;
      end
      htbd_pkg::ST_CUR: begin
        if (phase == htbd_pkg::PH_DECODE && !step_halt) begin
          state_next = htbd_pkg::ST_WALK;
        end else begin
          state_next = htbd_pkg::ST_FINISH;
        end
      end
      htbd_pkg::ST_WALK: begin
        if (!walk_stall && !(walk_more && !step_halt)) begin
          state_next = htbd_pkg::ST_FINISH;
        end
      end
      htbd_pkg::ST_FINISH: begin
        if (!last_reg || res_space) begin
          state_next = htbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = htbd_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_next = phase;
    halt_kind_next = halt_kind;
    cur_idx_next = cur_idx;
    child_idx_next = child_idx;
    child_ok_next = child_ok;
    root_entry_next = root_entry;
    root_ok_next = root_ok;
    bit_cnt_next = bit_cnt;
    byte_reg_next = byte_reg;
    last_reg_next = last_reg;
    symbols_next = symbols;
    cmd_pop = 1'b0;
    ram_we = 1'b0;
    ram_waddr = htbd_pkg::node_addr(cmd.idx);
    ram_wdata = cmd.entry;
    ram_re = 1'b0;
    ram_raddr = htbd_pkg::node_addr(root_node);
    res_push = 1'b0;
    res.kind = htbd_pkg::KIND_SYMBOL;
    res.symbol = rd_data.sym[7:0];
    res.count = symbols + 16'd1;
    res.last = 1'b0;
    case (state)
      htbd_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      htbd_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == htbd_pkg::OP_WRITE) begin
            ram_we = cmd.node_ok;
          end else begin
            byte_reg_next = cmd.data;
            last_reg_next = cmd.last;
            ram_re = 1'b1;
            ram_raddr = htbd_pkg::node_addr(root_node);
            if (phase == htbd_pkg::PH_IDLE) begin
              symbols_next = '0;
              halt_kind_next = htbd_pkg::KIND_DONE;
            end
          end
        end
      end
      htbd_pkg::ST_ROOT: begin
        root_entry_next = rd_data;
        root_ok_next = htbd_pkg::node_in_range(root_node);
        if (phase == htbd_pkg::PH_IDLE) begin
          if (root_start_ok) begin
            cur_idx_next = root_node;
            phase_next = htbd_pkg::PH_DECODE;
          end else begin
            cur_idx_next = '0;
            phase_next = htbd_pkg::PH_HALT;
            halt_kind_next = htbd_pkg::KIND_NOTREE;
          end
        end
        ram_re = 1'b1;
        ram_raddr = htbd_pkg::node_addr(cur_idx_next);
      end
      htbd_pkg::ST_CUR: begin
        if (phase == htbd_pkg::PH_DECODE) begin
          bit_cnt_next = 3'd0;
          if (step_halt) begin
            phase_next = htbd_pkg::PH_HALT;
            halt_kind_next = step_kind;
          end else begin
            child_idx_next = step_child;
            child_ok_next = htbd_pkg::node_in_range(step_child);
            ram_re = 1'b1;
            ram_raddr = htbd_pkg::node_addr(step_child);
          end
        end
      end
      htbd_pkg::ST_WALK: begin
        if (!walk_stall) begin
          if (walk_halt) begin
            phase_next = htbd_pkg::PH_HALT;
            halt_kind_next = walk_kind;
          end else begin
            if (walk_emit) begin
              res_push = 1'b1;
              symbols_next = symbols + 16'd1;
              cur_idx_next = root_node;
            end else begin
              cur_idx_next = child_idx;
            end
            if (walk_more) begin
              bit_cnt_next = bit_cnt + 3'd1;
              if (step_halt) begin
                phase_next = htbd_pkg::PH_HALT;
                halt_kind_next = step_kind;
              end else begin
                child_idx_next = step_child;
                child_ok_next = htbd_pkg::node_in_range(step_child);
                ram_re = 1'b1;
                ram_raddr = htbd_pkg::node_addr(step_child);
              end
            end
          end
        end
      end
      htbd_pkg::ST_FINISH: begin
        res.kind = (phase == htbd_pkg::PH_HALT) ? halt_kind : htbd_pkg::KIND_DONE;
        res.symbol = '0;
        res.count = symbols;
        res.last = 1'b1;
        if (last_reg && res_space) begin
          res_push = 1'b1;
          phase_next = htbd_pkg::PH_IDLE;
          cur_idx_next = '0;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htbd_pkg::ST_CLEAR;
      phase <= htbd_pkg::PH_IDLE;
      halt_kind <= htbd_pkg::KIND_DONE;
      cur_idx <= '0;
      symbols <= '0;
      clr_addr <= '0;
      root_node <= '0;
      max_output <= 16'hFFFF;
    end else begin
      state <= state_next;
      phase <= phase_next;
      halt_kind <= halt_kind_next;
      cur_idx <= cur_idx_next;
      symbols <= symbols_next;
      if (state == htbd_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + htbd_pkg::NODE_AW'(1);
      end
      if (cfg_valid) begin
        case (cfg_index)
          htbd_pkg::CFG_ROOT_NODE: root_node <= cfg_data[9:0];
          htbd_pkg::CFG_MAX_OUTPUT: max_output <= cfg_data;
          default: root_node <= root_node;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    child_idx <= child_idx_next;
    child_ok <= child_ok_next;
    root_entry <= root_entry_next;
    root_ok <= root_ok_next;
    bit_cnt <= bit_cnt_next;
    byte_reg <= byte_reg_next;
    last_reg <= last_reg_next;
  end

endmodule

// ----- rtl/huffman_tree_bit_decoder_unit.sv -----
// huffman_tree_bit_decoder_unit: top level of the huffman tree walk decoder
// depends on htbd_pkg, htbd_front, htbd_back, htbd_res_queue, htbd_ram
//
//   channel   direction  handshake             payload
//   input     in         push / full           opcode node_index node_symbol
//                                              left_child right_child
//                                              data_byte last_byte
//   result    out        empty / pop           kind symbol count last
//   config    in         cfg_valid / cfg_ready cfg_index cfg_data
//
// a node write is done from idle; a decode byte passes root fetch, current
// node fetch, up to eight walk steps and finish, an order set by the node
// table's single read port: each bit needs one dependent table read
// a result stall holds the walk; a two-beat command queue keeps input moving
// after reset all NODE_COUNT (1024) node table entries are cleared, full high
module huffman_tree_bit_decoder_unit (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic opcode,
  input  logic [9:0] node_index,
  input  logic [8:0] node_symbol,
  input  logic [9:0] left_child,
  input  logic [9:0] right_child,
  input  logic [7:0] data_byte,
  input  logic last_byte,
  output logic empty,
  input  logic pop,
  output logic [2:0] kind,
  output logic [7:0] symbol,
  output logic [15:0] count,
  output logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [15:0] cfg_data
);

  logic clearing;
  logic cmd_valid;
  htbd_pkg::cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  htbd_pkg::res_t res_in;
  logic res_space;
  htbd_pkg::res_t res_out;

  htbd_front u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .opcode(opcode),
    .node_index(node_index),
    .node_symbol(node_symbol),
    .left_child(left_child),
    .right_child(right_child),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .clearing(clearing),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop)
  );

  htbd_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop),
    .clearing(clearing),
    .res_push(res_push),
    .res(res_in),
    .res_space(res_space)
  );

  htbd_res_queue u_res_queue (
    .clk(clk),
    .rst(rst),
    .res_push(res_push),
    .res_in(res_in),
    .res_space(res_space),
    .empty(empty),
    .pop(pop),
    .res_out(res_out)
  );

  assign kind = res_out.kind;
  assign symbol = res_out.symbol;
  assign count = res_out.count;
  assign last = res_out.last;

endmodule

// ----- bench/huffman_tree_bit_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// huffman_tree_bit_decoder_unit_tb: self-checking bench for the tree walk decoder
// depends on htbd_pkg and huffman_tree_bit_decoder_unit; a directed table, then random
// trees and messages checked against a behavioral tree walk kept in this file
module huffman_tree_bit_decoder_unit_tb;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    htbd_pkg::op_t op;
    logic [9:0] idx;
    logic [8:0] sym;
    logic [9:0] left_idx;
    logic [9:0] right_idx;
    logic [7:0] data;
    logic fin;
  } huff_cmd_t;

  typedef struct packed {
    logic is_cfg;
    huff_cmd_t cmd;
    logic reg_idx;
    logic [15:0] reg_val;
    logic fixed;
    htbd_pkg::kind_t fixed_kind;
    logic [15:0] fixed_count;
  } script_row_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic opcode;
  logic [9:0] node_index;
  logic [8:0] node_symbol;
  logic [9:0] left_child;
  logic [9:0] right_child;
  logic [7:0] data_byte;
  logic last_byte;
  logic empty;
  logic pop;
  logic [2:0] kind;
  logic [7:0] symbol;
  logic [15:0] count;
  logic last;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [15:0] cfg_data;

  // decoder state as seen from outside
  logic [8:0] tbl_sym [htbd_pkg::NODE_COUNT];
  logic [9:0] tbl_left [htbd_pkg::NODE_COUNT];
  logic [9:0] tbl_right [htbd_pkg::NODE_COUNT];
  logic tbl_known [htbd_pkg::NODE_COUNT];
  logic [9:0] walk_node;
  logic [15:0] sym_count;
  htbd_pkg::phase_t msg_phase;
  htbd_pkg::kind_t stop_kind;
  logic [9:0] cfg_root;
  logic [15:0] cfg_max;

  htbd_pkg::res_t step_results[$];
  htbd_pkg::res_t pending[$];
  int fail_count;
  int phase_items;
  int push_gap_pct;
  int pop_gap_pct;

  huffman_tree_bit_decoder_unit i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .opcode(opcode),
    .node_index(node_index),
    .node_symbol(node_symbol),
    .left_child(left_child),
    .right_child(right_child),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .symbol(symbol),
    .count(count),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic node_ok(logic [9:0] n);
    return int'(n) < htbd_pkg::NODE_COUNT && tbl_known[n];
  endfunction

  function automatic void stop_walk(htbd_pkg::kind_t k);
    msg_phase = htbd_pkg::PH_HALT;
    stop_kind = k;
  endfunction

  // expected results of one accepted command, left in step_results
  function automatic void walk_predict(huff_cmd_t c);
    logic [9:0] child;
    logic [8:0] s;
    htbd_pkg::res_t r;
    step_results.delete();
    if (c.op == htbd_pkg::OP_WRITE) begin
      if (int'(c.idx) < htbd_pkg::NODE_COUNT) begin
        tbl_sym[c.idx] = c.sym;
        tbl_left[c.idx] = c.left_idx;
        tbl_right[c.idx] = c.right_idx;
        tbl_known[c.idx] = 1'b1;
      end
      return;
    end
    if (msg_phase == htbd_pkg::PH_IDLE) begin
      sym_count = '0;
      stop_kind = htbd_pkg::KIND_DONE;
      if (node_ok(cfg_root)) begin
        walk_node = cfg_root;
        msg_phase = htbd_pkg::PH_DECODE;
      end else begin
        walk_node = '0;
        stop_walk(htbd_pkg::KIND_NOTREE);
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (msg_phase != htbd_pkg::PH_DECODE) break;
      if (!node_ok(walk_node)) begin
        stop_walk(htbd_pkg::KIND_DONE);
      end else if (tbl_sym[walk_node] != htbd_pkg::INTERNAL_SYM) begin
        stop_walk(tbl_sym[walk_node] > htbd_pkg::MAX_BYTE_SYM ? htbd_pkg::KIND_BAD
                                                               : htbd_pkg::KIND_FULL);
      end else begin
        child = c.data[i] ? tbl_right[walk_node] : tbl_left[walk_node];
        s = tbl_sym[child];
        if (!node_ok(child)) begin
          stop_walk(htbd_pkg::KIND_DONE);
        end else if (s == htbd_pkg::INTERNAL_SYM) begin
          walk_node = child;
        end else if (s > htbd_pkg::MAX_BYTE_SYM) begin
          stop_walk(htbd_pkg::KIND_BAD);
        end else if (sym_count == cfg_max) begin
          stop_walk(htbd_pkg::KIND_FULL);
        end else begin
          sym_count = sym_count + 16'd1;
          r.kind = htbd_pkg::KIND_SYMBOL;
          r.symbol = s[7:0];
          r.count = sym_count;
          r.last = 1'b0;
          step_results.push_back(r);
          walk_node = cfg_root;
        end
      end
    end
    if (c.fin) begin
      r.kind = (msg_phase == htbd_pkg::PH_HALT) ? stop_kind : htbd_pkg::KIND_DONE;
      r.symbol = '0;
      r.count = sym_count;
      r.last = 1'b1;
      step_results.push_back(r);
      msg_phase = htbd_pkg::PH_IDLE;
      walk_node = '0;
    end
  endfunction

  function automatic huff_cmd_t mk_write(logic [9:0] idx, logic [8:0] sym,
                                         logic [9:0] l, logic [9:0] r);
    huff_cmd_t c;
    c.op = htbd_pkg::OP_WRITE;
    c.idx = idx;
    c.sym = sym;
    c.left_idx = l;
    c.right_idx = r;
    c.data = 8'($urandom);
    c.fin = 1'($urandom);
    return c;
  endfunction

  function automatic huff_cmd_t mk_byte(logic [7:0] data, logic fin);
    huff_cmd_t c;
    c.op = htbd_pkg::OP_DECODE;
    c.idx = 10'($urandom);
    c.sym = 9'($urandom);
    c.left_idx = 10'($urandom);
    c.right_idx = 10'($urandom);
    c.data = data;
    c.fin = fin;
    return c;
  endfunction

  function automatic script_row_t row_cmd(huff_cmd_t c);
    script_row_t row;
    row = '0;
    row.cmd = c;
    return row;
  endfunction

  function automatic script_row_t row_fixed(logic [7:0] data, htbd_pkg::kind_t k,
                                            logic [15:0] n);
    script_row_t row;
    row = row_cmd(mk_byte(data, 1'b1));
    row.fixed = 1'b1;
    row.fixed_kind = k;
    row.fixed_count = n;
    return row;
  endfunction

  function automatic script_row_t row_cfg(logic idx, logic [15:0] val);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic send_cmd(huff_cmd_t c, logic fixed, htbd_pkg::res_t fixed_res);
    while ($urandom_range(0, 99) < push_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    opcode <= c.op;
    node_index <= c.idx;
    node_symbol <= c.sym;
    left_child <= c.left_idx;
    right_child <= c.right_idx;
    data_byte <= c.data;
    last_byte <= c.fin;
    do @(posedge clk); while (full);
    walk_predict(c);
    if (fixed) pending.push_back(fixed_res);
    else foreach (step_results[i]) pending.push_back(step_results[i]);
    phase_items++;
  endtask

  task automatic send_plain(huff_cmd_t c);
    send_cmd(c, 1'b0, '0);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == htbd_pkg::CFG_ROOT_NODE) cfg_root = val[9:0];
    else cfg_max = val;
  endtask

  // random full binary tree whose top node lands on root_at
  task automatic build_tree(logic [9:0] root_at, int leaves);
    bit taken [htbd_pkg::NODE_COUNT];
    logic [9:0] pool[$];
    logic [9:0] a;
    logic [9:0] b;
    logic [9:0] n;
    logic [8:0] leaf_sym;
    int j;
    taken[root_at] = 1'b1;
    for (int i = 0; i < leaves; i++) begin
      do n = 10'($urandom_range(0, htbd_pkg::NODE_COUNT - 1)); while (taken[n]);
      taken[n] = 1'b1;
      leaf_sym = ($urandom_range(0, 19) == 0) ? 9'd256 : 9'($urandom_range(0, 255));
      send_plain(mk_write(n, leaf_sym, 10'($urandom), 10'($urandom)));
      pool.push_back(n);
    end
    while (pool.size() > 1) begin
      j = $urandom_range(0, pool.size() - 1);
      a = pool[j];
      pool.delete(j);
      j = $urandom_range(0, pool.size() - 1);
      b = pool[j];
      pool.delete(j);
      if (pool.size() == 0) begin
        n = root_at;
      end else begin
        do n = 10'($urandom_range(0, htbd_pkg::NODE_COUNT - 1)); while (taken[n]);
        taken[n] = 1'b1;
      end
      send_plain(mk_write(n, htbd_pkg::INTERNAL_SYM, a, b));
      pool.push_back(n);
    end
  endtask

  task automatic send_message(int nbytes);
    for (int k = 0; k < nbytes; k++) send_plain(mk_byte(8'($urandom), k == nbytes - 1));
  endtask

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      fail_count++;
    end
  endtask

  task automatic check_beat();
    htbd_pkg::res_t want;
    if (pending.size() == 0) begin
      $display("%0t: extra result, expected none, got kind %0d symbol %0d count %0d last %0d",
               $time, kind, symbol, count, last);
      fail_count++;
    end else begin
      want = pending.pop_front();
      cmp_field("kind", 16'(want.kind), 16'(kind));
      cmp_field("symbol", 16'(want.symbol), 16'(symbol));
      cmp_field("count", want.count, count);
      cmp_field("last", 16'(want.last), 16'(last));
    end
  endtask

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_beat();
      pop <= ($urandom_range(0, 99) >= pop_gap_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    script_row_t script[$];
    htbd_pkg::res_t fixed_res;
    int r;
    for (int i = 0; i < htbd_pkg::NODE_COUNT; i++) tbl_known[i] = 1'b0;
    walk_node = '0;
    sym_count = '0;
    msg_phase = htbd_pkg::PH_IDLE;
    stop_kind = htbd_pkg::KIND_DONE;
    cfg_root = '0;
    cfg_max = 16'hffff;
    fail_count = 0;
    phase_items = 0;
    push_gap_pct = 35;
    pop_gap_pct = 71;

    rst <= 1'b1;
    push <= 1'b0;
    opcode <= htbd_pkg::OP_WRITE;
    node_index <= '0;
    node_symbol <= '0;
    left_child <= '0;
    right_child <= '0;
    data_byte <= '0;
    last_byte <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= htbd_pkg::CFG_ROOT_NODE;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table, small tree with extreme symbols and links, then the error paths
    script.push_back(row_fixed(8'h00, htbd_pkg::KIND_NOTREE, 16'd0));
    script.push_back(row_cmd(mk_write(10'd0, htbd_pkg::INTERNAL_SYM, 10'd1, 10'd2)));
    script.push_back(row_cmd(mk_write(10'd1, 9'd0, 10'd0, 10'd0)));
    script.push_back(row_cmd(mk_write(10'd2, htbd_pkg::INTERNAL_SYM, 10'd3, 10'd1023)));
    script.push_back(row_cmd(mk_write(10'd3, 9'd255, 10'd1023, 10'd1023)));
    script.push_back(row_cmd(mk_write(10'd1023, 9'd256, 10'd0, 10'd0)));
    script.push_back(row_cmd(mk_byte(8'h00, 1'b0)));
    script.push_back(row_cmd(mk_byte(8'hff, 1'b1)));
    script.push_back(row_cmd(mk_byte(8'h80, 1'b0)));
    script.push_back(row_cmd(mk_write(10'd2, 9'd9, 10'd0, 10'd0)));
    script.push_back(row_cmd(mk_byte(8'h00, 1'b1)));
    script.push_back(row_cmd(mk_write(10'd2, htbd_pkg::INTERNAL_SYM, 10'd3, 10'd1023)));
    script.push_back(row_cfg(htbd_pkg::CFG_MAX_OUTPUT, 16'd0));
    script.push_back(row_fixed(8'h00, htbd_pkg::KIND_FULL, 16'd0));
    script.push_back(row_cfg(htbd_pkg::CFG_MAX_OUTPUT, 16'hffff));
    script.push_back(row_cmd(mk_byte(8'hff, 1'b0)));
    script.push_back(row_cmd(mk_byte(8'h00, 1'b0)));
    script.push_back(row_cmd(mk_byte(8'h80, 1'b1)));
    script.push_back(row_cmd(mk_write(10'd0, htbd_pkg::INTERNAL_SYM, 10'd1, 10'd600)));
    script.push_back(row_cmd(mk_byte(8'h02, 1'b1)));
    script.push_back(row_cfg(htbd_pkg::CFG_ROOT_NODE, 16'hfc05));
    script.push_back(row_fixed(8'ha5, htbd_pkg::KIND_NOTREE, 16'd0));
    script.push_back(row_cmd(mk_write(10'd5, 9'd7, 10'd0, 10'd0)));
    script.push_back(row_fixed(8'h00, htbd_pkg::KIND_FULL, 16'd0));
    script.push_back(row_cfg(htbd_pkg::CFG_ROOT_NODE, 16'd1023));
    script.push_back(row_fixed(8'hff, htbd_pkg::KIND_BAD, 16'd0));

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        fixed_res.kind = script[i].fixed_kind;
        fixed_res.symbol = '0;
        fixed_res.count = script[i].fixed_count;
        fixed_res.last = 1'b1;
        send_cmd(script[i].cmd, script[i].fixed, fixed_res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_reg(htbd_pkg::CFG_ROOT_NODE, 16'($urandom));
          write_reg(htbd_pkg::CFG_MAX_OUTPUT, 16'hffff);
        end
        1: begin
          push_gap_pct = 71;
          pop_gap_pct = 35;
          write_reg(htbd_pkg::CFG_ROOT_NODE, 16'd1023);
          write_reg(htbd_pkg::CFG_MAX_OUTPUT, 16'($urandom_range(0, 15)));
        end
        default: begin
          push_gap_pct = 0;
          pop_gap_pct = 0;
          write_reg(htbd_pkg::CFG_ROOT_NODE, 16'd0);
          write_reg(htbd_pkg::CFG_MAX_OUTPUT, 16'($urandom_range(1, 4)));
        end
      endcase
      phase_items = 0;
      build_tree(cfg_root, $urandom_range(2, 12));
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          send_plain(mk_write(10'($urandom), 9'($urandom_range(0, 257)),
                              10'($urandom), 10'($urandom)));
        end else if (r == 2) begin
          build_tree(cfg_root, $urandom_range(2, 12));
        end else begin
          send_message($urandom_range(1, 4));
        end
      end
      // close any message left open by the stimulus
      if (msg_phase != htbd_pkg::PH_IDLE) send_plain(mk_byte(8'($urandom), 1'b1));
    end

    settle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- huffman_tree_bit_decoder_unit.f -----
rtl/htbd_pkg.sv
rtl/htbd_ram.sv
rtl/htbd_front.sv
rtl/htbd_res_queue.sv
rtl/htbd_back.sv
rtl/huffman_tree_bit_decoder_unit.sv
bench/huffman_tree_bit_decoder_unit_tb.sv
